FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define ORSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while in reset.
`define ORSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/orsp_pkg.sv
// Package for the object record stream parser: codes, constants and the
// result struct. No dependencies.
package orsp_pkg;

  localparam int FLAG_WIDTH_DEF = 32;
  localparam int OUT_FLAG_W     = 32;

  localparam logic [15:0] RESET_RECORD_ID = 16'd100;

  // Option codes
  localparam logic [7:0] OPT_SPEED    = 8'h00;
  localparam logic [7:0] OPT_WR_LIMIT = 8'h09;
  localparam logic [7:0] OPT_RD_LIMIT = 8'h0A;
  localparam logic [7:0] OPT_LIGHT    = 8'h16;
  localparam logic [7:0] OPT_UNUSED   = 8'h17;
  localparam logic [7:0] OPT_OFFSET   = 8'h19;
  localparam logic [7:0] OPT_RAISE    = 8'h1A;
  localparam logic [7:0] OPT_MAP_COL  = 8'h1D;
  localparam logic [7:0] OPT_HELP     = 8'h1E;
  localparam logic [7:0] OPT_END      = 8'hFF;

  // Attribute codes
  localparam logic [3:0] ATTR_SPEED    = 4'd0;
  localparam logic [3:0] ATTR_WR_LIMIT = 4'd1;
  localparam logic [3:0] ATTR_RD_LIMIT = 4'd2;
  localparam logic [3:0] ATTR_LIGHT    = 4'd3;
  localparam logic [3:0] ATTR_OFFSET   = 4'd5;
  localparam logic [3:0] ATTR_RAISE    = 4'd7;
  localparam logic [3:0] ATTR_MAP_COL  = 4'd8;
  localparam logic [3:0] ATTR_HELP     = 4'd9;

  // Result kinds
  localparam logic KIND_ATTR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [15:0]           record_id;
    logic                  result_kind;
    logic [3:0]            attribute_code;
    logic [15:0]           attribute_value;
    logic [OUT_FLAG_W-1:0] flag_bits;
    logic [7:0]            help_code;
    logic [31:0]           sprite_total;
  } orsp_result_t;

endpackage

FILE: design/orsp_parse.sv
// Record parser state machine: consumes one byte per step and produces at
// most one result per byte. Depends on orsp_pkg.
module orsp_parse
  import orsp_pkg::*;
#(
  parameter int FLAG_WIDTH = FLAG_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  output logic         res_vld,
  output orsp_result_t res
);

  localparam logic [3:0] PH_OPTION = 4'd0;
  localparam logic [3:0] PH_ARG_LO = 4'd1;
  localparam logic [3:0] PH_ARG_HI = 4'd2;
  localparam logic [3:0] PH_HELP   = 4'd3;
  localparam logic [3:0] PH_WIDTH  = 4'd4;
  localparam logic [3:0] PH_HEIGHT = 4'd5;
  localparam logic [3:0] PH_EXTRA  = 4'd6;
  localparam logic [3:0] PH_COUNT  = 4'd7;
  localparam logic [3:0] PH_SKIP   = 4'd8;

  localparam logic [2:0] LAST_COUNT = 3'd4;

  logic [3:0]            phase_r, phase_nxt;
  logic [3:0]            pend_r, pend_nxt;
  logic [1:0]            args_r, args_nxt;
  logic [7:0]            lo_r, lo_nxt;
  logic [FLAG_WIDTH-1:0] flags_r, flags_nxt;
  logic [7:0]            help_r, help_nxt;
  logic [15:0]           id_r, id_nxt;
  logic [2:0]            hidx_r, hidx_nxt;
  logic                  wot_r, wot_nxt;
  logic [31:0]           prod_r, prod_nxt;
  logic [32:0]           skip_r, skip_nxt;

  logic [31:0] prod_mul;
  logic        wot_new;
  logic        fin;
  logic [31:0] fin_total;

  assign prod_mul = prod_r * {24'd0, data_byte};
  assign wot_new  = wot_r | (data_byte > 8'd1);

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    args_nxt  = args_r;
    lo_nxt    = lo_r;
    flags_nxt = flags_r;
    help_nxt  = help_r;
    id_nxt    = id_r;
    hidx_nxt  = hidx_r;
    wot_nxt   = wot_r;
    prod_nxt  = prod_r;
    skip_nxt  = skip_r;
    fin       = 1'b0;
    fin_total = prod_r;
    res_vld   = 1'b0;
    res       = '0;
    res.record_id = id_r;

    unique case (phase_r)
      PH_OPTION: begin
        if (data_byte == OPT_END) begin
          phase_nxt = PH_WIDTH;
        end else if (data_byte == OPT_HELP) begin
          phase_nxt = PH_HELP;
        end else if (data_byte[7:5] == 3'd0 && data_byte != OPT_UNUSED) begin
          if (data_byte != OPT_SPEED)
            flags_nxt = flags_r | (FLAG_WIDTH'(1) << data_byte[4:0]);
          unique case (data_byte)
            OPT_SPEED: begin
              pend_nxt = ATTR_SPEED;    args_nxt = 2'd1; phase_nxt = PH_ARG_LO;
            end
            OPT_WR_LIMIT: begin
              pend_nxt = ATTR_WR_LIMIT; args_nxt = 2'd1; phase_nxt = PH_ARG_LO;
            end
            OPT_RD_LIMIT: begin
              pend_nxt = ATTR_RD_LIMIT; args_nxt = 2'd1; phase_nxt = PH_ARG_LO;
            end
            OPT_LIGHT: begin
              pend_nxt = ATTR_LIGHT;    args_nxt = 2'd2; phase_nxt = PH_ARG_LO;
            end
            OPT_OFFSET: begin
              pend_nxt = ATTR_OFFSET;   args_nxt = 2'd2; phase_nxt = PH_ARG_LO;
            end
            OPT_RAISE: begin
              pend_nxt = ATTR_RAISE;    args_nxt = 2'd1; phase_nxt = PH_ARG_LO;
            end
            OPT_MAP_COL: begin
              pend_nxt = ATTR_MAP_COL;  args_nxt = 2'd1; phase_nxt = PH_ARG_LO;
            end
            default: ;
          endcase
        end
      end
      PH_ARG_LO: begin
        lo_nxt    = data_byte;
        phase_nxt = PH_ARG_HI;
      end
      PH_ARG_HI: begin
        res_vld             = 1'b1;
        res.result_kind     = KIND_ATTR;
        res.attribute_code  = pend_r;
        res.attribute_value = {data_byte, lo_r};
        if (args_r > 2'd1) begin
          args_nxt  = args_r - 2'd1;
          pend_nxt  = pend_r + 4'd1;
          phase_nxt = PH_ARG_LO;
        end else begin
          args_nxt  = 2'd0;
          phase_nxt = PH_OPTION;
        end
      end
      PH_HELP: begin
        help_nxt            = data_byte;
        res_vld             = 1'b1;
        res.result_kind     = KIND_ATTR;
        res.attribute_code  = ATTR_HELP;
        res.attribute_value = {8'd0, data_byte};
        phase_nxt           = PH_OPTION;
      end
      PH_WIDTH, PH_HEIGHT: begin
        wot_nxt   = wot_new;
        prod_nxt  = prod_mul;
        hidx_nxt  = 3'd0;
        if (phase_r == PH_WIDTH)
          phase_nxt = PH_HEIGHT;
        else
          phase_nxt = wot_new ? PH_EXTRA : PH_COUNT;
      end
      PH_EXTRA: begin
        phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        prod_nxt = prod_mul;
        if (hidx_r < LAST_COUNT) begin
          hidx_nxt = hidx_r + 3'd1;
        end else begin
          skip_nxt = {prod_mul, 1'b0};
          if (prod_mul == 32'd0) begin
            fin       = 1'b1;
            fin_total = prod_mul;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (skip_r <= 33'd1) begin
          fin = 1'b1;
        end else begin
          skip_nxt = skip_r - 33'd1;
        end
      end
      default: begin
        phase_nxt = PH_OPTION;
      end
    endcase

    // record end: emit summary and clear per-record state
    if (fin) begin
      res_vld          = 1'b1;
      res.result_kind  = KIND_END;
      res.flag_bits    = flags_r[OUT_FLAG_W-1:0];
      res.help_code    = help_r;
      res.sprite_total = fin_total;
      id_nxt    = id_r + 16'd1;
      phase_nxt = PH_OPTION;
      pend_nxt  = 4'd0;
      args_nxt  = 2'd0;
      lo_nxt    = 8'd0;
      flags_nxt = '0;
      help_nxt  = 8'd0;
      hidx_nxt  = 3'd0;
      wot_nxt   = 1'b0;
      prod_nxt  = 32'd1;
      skip_nxt  = 33'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPTION;
      pend_r  <= 4'd0;
      args_r  <= 2'd0;
      lo_r    <= 8'd0;
      flags_r <= '0;
      help_r  <= 8'd0;
      id_r    <= RESET_RECORD_ID;
      hidx_r  <= 3'd0;
      wot_r   <= 1'b0;
      prod_r  <= 32'd1;
      skip_r  <= 33'd0;
    end else if (cfg_wr_en) begin
      id_r <= cfg_wr_data;
    end else if (step) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      args_r  <= args_nxt;
      lo_r    <= lo_nxt;
      flags_r <= flags_nxt;
      help_r  <= help_nxt;
      id_r    <= id_nxt;
      hidx_r  <= hidx_nxt;
      wot_r   <= wot_nxt;
      prod_r  <= prod_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

FILE: design/object_record_stream_parser_core.sv
// A byte accepted into the input register passes the parse stage, and any
// result goes into the result register. One byte per cycle while the result
// register is free or drained; the sprite-count multiply (32x8) sits in the
// single parse stage. Reset: synchronous, active low; parser returns to the
// option phase, record id to 100; input and result registers are emptied.
//
// Top level of the object record stream parser. Depends on orsp_pkg and
// orsp_parse.
module object_record_stream_parser_core
  import orsp_pkg::*;
#(
  parameter int FLAG_WIDTH = FLAG_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  // results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_record_id,
  output logic        out_result_kind,
  output logic [3:0]  out_attribute_code,
  output logic [15:0] out_attribute_value,
  output logic [31:0] out_flag_bits,
  output logic [7:0]  out_help_code,
  output logic [31:0] out_sprite_total,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // Input register: holds one byte request until the parse stage can take it.
  logic         in_vld_r;
  logic [7:0]   in_byte_r;

  // Result register.
  logic         out_vld_r;
  orsp_result_t out_res_r;

  // Parse stage
  logic         advance;
  logic         res_vld;
  orsp_result_t res;

  // The stage advances whenever the result register is free or being
  // drained this cycle; a byte that yields no result still waits for that,
  // which keeps the control trivial and costs nothing at full rate.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      in_byte_r <= in_data_byte;
  end

  orsp_parse #(
    .FLAG_WIDTH (FLAG_WIDTH)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .data_byte   (in_byte_r),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_vld     (res_vld),
    .res         (res)
  );

  // Result register: loads on advance, otherwise drains on out_ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_vld;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld)
      out_res_r <= res;
  end

  assign out_valid           = out_vld_r;
  assign out_record_id       = out_res_r.record_id;
  assign out_result_kind     = out_res_r.result_kind;
  assign out_attribute_code  = out_res_r.attribute_code;
  assign out_attribute_value = out_res_r.attribute_value;
  assign out_flag_bits       = out_res_r.flag_bits;
  assign out_help_code       = out_res_r.help_code;
  assign out_sprite_total    = out_res_r.sprite_total;

endmodule

FILE: design/orsp_checker.sv
// Port-level checker for the object record stream parser, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module orsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_record_id,
  input logic        out_result_kind,
  input logic [3:0]  out_attribute_code,
  input logic [15:0] out_attribute_value,
  input logic [31:0] out_flag_bits,
  input logic [7:0]  out_help_code,
  input logic [31:0] out_sprite_total
);

  `ORSP_ASSERT_IMP(a_end_no_attr, out_valid && out_result_kind, out_attribute_code == 4'd0 && out_attribute_value == 16'd0, "record end carries attribute data")
  `ORSP_ASSERT_IMP(a_attr_no_summary, out_valid && !out_result_kind, out_flag_bits == 32'd0 && out_help_code == 8'd0 && out_sprite_total == 32'd0, "attribute carries record summary")
  `ORSP_ASSERT_IMP(a_flag_gaps, out_valid, !out_flag_bits[0] && !out_flag_bits[23] && !out_flag_bits[30] && (out_result_kind || out_attribute_code <= 4'd9), "illegal flag bit or attribute code")
  `ORSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_record_id) && $stable(out_result_kind) && $stable(out_attribute_value), "stalled result changed")
  `ORSP_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data_byte), "stalled request changed")

endmodule

bind object_record_stream_parser_core orsp_checker u_orsp_checker (.*);
